### rtl/sqvb_pkg.sv
`default_nettype none

package sqvb_pkg;

    localparam int DEF_MAX_LAYERS  = 8;
    localparam int DEF_MAX_TILES   = 256;

    localparam int IN_DATA_W   = 120;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 112;
    localparam int OUT_USER_W  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SLOT_W      = 14;
    localparam int TEX_W       = 17;
    localparam int TEXEL_W     = 13;

    localparam logic [2:0] K_LAST = 3'd5;

    typedef enum logic [1:0] {
        MODE_ADD       = 2'd0,
        MODE_CLEAR_ONE = 2'd1,
        MODE_CLEAR_ALL = 2'd2,
        MODE_NONE      = 2'd3
    } sqvb_mode_t;

    typedef enum logic [2:0] {
        ST_VERTEX     = 3'd0,
        ST_CLEARED    = 3'd1,
        ST_NO_TEXTURE = 3'd2,
        ST_LAYER_FULL = 3'd3,
        ST_BAD_LAYER  = 3'd4
    } sqvb_status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEFAULT_LAYER  = 3'd0,
        REG_LAYERS_IN_USE  = 3'd1,
        REG_TILES_PER_LAYER = 3'd2,
        REG_RECIP_WIDTH    = 3'd3,
        REG_RECIP_HEIGHT   = 3'd4,
        REG_TEXTURE_LOADED = 3'd5
    } sqvb_reg_t;

    // Input item as it sits in s_tdata, highest bits first.
    typedef struct packed {
        logic [1:0]         pad;
        logic [31:0]        rgba;
        logic [1:0]         flip;
        logic [11:0]        quad_height;
        logic [11:0]        quad_width;
        logic signed [15:0] screen_y;
        logic signed [15:0] screen_x;
        logic [11:0]        sheet_y;
        logic [11:0]        sheet_x;
        logic signed [3:0]  layer;
    } sqvb_item_t;

    // One checked quad, ready for the emitter. Status results carry zeros.
    typedef struct packed {
        sqvb_status_t       status;
        logic [SLOT_W-1:0]  base;
        logic signed [15:0] xl;
        logic signed [15:0] xr;
        logic signed [15:0] yt;
        logic signed [15:0] yb;
        logic [TEX_W-1:0]   u0;
        logic [TEX_W-1:0]   u1;
        logic [TEX_W-1:0]   v0;
        logic [TEX_W-1:0]   v1;
        logic [31:0]        rgba;
    } sqvb_quad_t;

    typedef struct packed {
        logic wr_en;
        logic clr_all;
    } sqvb_cnt_wr_t;

    function automatic logic [2:0] eff_layer(input logic signed [3:0] layer,
                                             input logic [2:0] def_layer);
        logic [2:0] res;
        res = (layer == -4'sd1) ? def_layer : layer[2:0];
        return res;
    endfunction

    function automatic logic [TEX_W-1:0] tex_coord(input logic [TEXEL_W-1:0] texel,
                                                   input logic [31:0] recip);
        logic [TEXEL_W+31:0] prod;
        logic [TEX_W-1:0]    res;
        prod = {32'd0, texel} * {{TEXEL_W{1'b0}}, recip};
        if (|prod[TEXEL_W+31:TEX_W+16])
        begin
            res = '1;
        end
        else
        begin
            res = prod[TEX_W+15:16];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] res;
        if (v[16] != v[15])
        begin
            res = v[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/sqvb_counts.sv
`default_nettype none

module sqvb_counts
    import sqvb_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    parameter int MAX_TILES  = DEF_MAX_TILES,
    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
    localparam int CW = $clog2(MAX_TILES + 1)
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rd_en,
    input  wire logic [LW-1:0] rd_addr,
    input  wire sqvb_cnt_wr_t wr,
    input  wire logic [LW-1:0] wr_addr,
    input  wire logic [CW-1:0] wr_data,
    output logic [CW-1:0]     count
);

    logic [CW-1:0]         mem [MAX_LAYERS];
    logic [CW-1:0]         mem_q_reg;
    logic [CW-1:0]         byp_data_reg;
    logic                  byp_hit_reg;
    logic                  byp_zero_reg;
    logic                  vld_q_reg;
    logic [MAX_LAYERS-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A valid bit per layer lets a clear of all layers skip writing the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            vld_q_reg    <= 1'b0;
            byp_hit_reg  <= 1'b0;
            byp_zero_reg <= 1'b0;
        end
        else
        begin
            if (wr.clr_all)
            begin
                vld_reg <= '0;
            end
            else if (wr.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // An update landing on the same edge as the read is forwarded.
                vld_q_reg    <= vld_reg[rd_addr];
                byp_hit_reg  <= wr.wr_en && (wr_addr == rd_addr);
                byp_zero_reg <= wr.clr_all;
            end
        end
    end

    always_comb
    begin
        if (byp_zero_reg)
        begin
            count = '0;
        end
        else if (byp_hit_reg)
        begin
            count = byp_data_reg;
        end
        else if (vld_q_reg)
        begin
            count = mem_q_reg;
        end
        else
        begin
            count = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/sqvb_quad.sv
`default_nettype none

module sqvb_quad
    import sqvb_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    parameter int MAX_TILES  = DEF_MAX_TILES,
    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
    localparam int CW = $clog2(MAX_TILES + 1)
)
(
    input  wire sqvb_item_t    item,
    input  wire sqvb_mode_t    mode,
    input  wire logic [2:0]    default_layer,
    input  wire logic [3:0]    layers_in_use,
    input  wire logic [8:0]    tiles_per_layer,
    input  wire logic [31:0]   recip_w,
    input  wire logic [31:0]   recip_h,
    input  wire logic          texture_loaded,
    input  wire logic [CW-1:0] count,
    output sqvb_quad_t         quad,
    output sqvb_cnt_wr_t       wr,
    output logic [LW-1:0]      wr_addr,
    output logic [CW-1:0]      wr_data
);

    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam int BW   = 3 + CW + 1;

    logic [2:0]         eff;
    logic               bad;
    logic [CMPW-1:0]    tpl_w;
    logic [CMPW-1:0]    cap_w;
    logic               full;
    logic [BW-1:0]      base_w;
    logic [TEX_W-1:0]   u_near;
    logic [TEX_W-1:0]   u_far;
    logic [TEX_W-1:0]   v_near;
    logic [TEX_W-1:0]   v_far;
    logic signed [16:0] x_r;
    logic signed [16:0] y_b;

    always_comb
    begin
        eff   = eff_layer(item.layer, default_layer);
        bad   = (item.layer < 0 && item.layer != -4'sd1)
              || ({1'b0, eff} >= layers_in_use)
              || (32'(eff) >= 32'(MAX_LAYERS));
        tpl_w = CMPW'(tiles_per_layer);
        cap_w = (tpl_w > CMPW'(MAX_TILES)) ? CMPW'(MAX_TILES) : tpl_w;
        full  = CMPW'(count) >= cap_w;

        base_w = BW'(eff) * BW'(CW'(cap_w)) + BW'(count);

        u_near = tex_coord(TEXEL_W'(item.sheet_x), recip_w);
        u_far  = tex_coord(TEXEL_W'(item.sheet_x) + TEXEL_W'(item.quad_width), recip_w);
        v_near = tex_coord(TEXEL_W'(item.sheet_y), recip_h);
        v_far  = tex_coord(TEXEL_W'(item.sheet_y) + TEXEL_W'(item.quad_height), recip_h);
        x_r    = {item.screen_x[15], item.screen_x} + $signed({5'd0, item.quad_width});
        y_b    = {item.screen_y[15], item.screen_y} + $signed({5'd0, item.quad_height});

        quad       = '0;
        wr         = '0;
        wr_addr    = LW'(eff);
        wr_data    = '0;

        case (mode)
            MODE_CLEAR_ALL:
            begin
                quad.status = ST_CLEARED;
                wr.clr_all  = 1'b1;
            end
            MODE_CLEAR_ONE:
            begin
                if (item.layer == -4'sd1)
                begin
                    quad.status = ST_CLEARED;
                    wr.clr_all  = 1'b1;
                end
                else if (bad)
                begin
                    quad.status = ST_BAD_LAYER;
                end
                else
                begin
                    quad.status = ST_CLEARED;
                    wr.wr_en    = 1'b1;
                end
            end
            MODE_ADD:
            begin
                if (!texture_loaded)
                begin
                    quad.status = ST_NO_TEXTURE;
                end
                else if (bad)
                begin
                    quad.status = ST_BAD_LAYER;
                end
                else if (full)
                begin
                    quad.status = ST_LAYER_FULL;
                end
                else
                begin
                    quad.status = ST_VERTEX;
                    quad.base   = SLOT_W'(base_w);
                    quad.xl     = sat16({item.screen_x[15], item.screen_x});
                    quad.xr     = sat16(x_r);
                    quad.yt     = sat16({item.screen_y[15], item.screen_y});
                    quad.yb     = sat16(y_b);
                    quad.u0     = item.flip[0] ? u_far : u_near;
                    quad.u1     = item.flip[0] ? u_near : u_far;
                    quad.v0     = item.flip[1] ? v_far : v_near;
                    quad.v1     = item.flip[1] ? v_near : v_far;
                    quad.rgba   = item.rgba;
                    wr.wr_en    = 1'b1;
                    wr_data     = count + CW'(1);
                end
            end
            default:
            begin
                quad = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sqvb_emit.sv
`default_nettype none

module sqvb_emit
    import sqvb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire sqvb_quad_t            quad_in,
    output logic                       free,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    sqvb_quad_t        quad_reg;
    logic              b_valid_reg;
    logic [2:0]        k_reg;
    logic              is_vert;
    logic              right;
    logic              bottom;
    logic              fire;
    logic              done;
    logic [SLOT_W-1:0] slot;

    always_comb
    begin
        is_vert  = (quad_reg.status == ST_VERTEX);
        right    = (k_reg == 3'd2) || (k_reg >= 3'd4);
        bottom   = (k_reg >= 3'd3);
        m_tvalid = b_valid_reg;
        m_tlast  = !is_vert || (k_reg == K_LAST);
        fire     = b_valid_reg && m_tready;
        done     = fire && m_tlast;
        free     = !b_valid_reg || done;
        slot     = SLOT_W'({quad_reg.base, 2'b00}) + SLOT_W'({quad_reg.base, 1'b0})
                 + SLOT_W'(k_reg);
        m_tuser  = quad_reg.status;
        m_tdata  = {quad_reg.rgba,
                    bottom ? quad_reg.v1 : quad_reg.v0,
                    right  ? quad_reg.u1 : quad_reg.u0,
                    bottom ? quad_reg.yb : quad_reg.yt,
                    right  ? quad_reg.xr : quad_reg.xl,
                    slot};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            k_reg       <= '0;
        end
        else if (load)
        begin
            b_valid_reg <= 1'b1;
            k_reg       <= '0;
        end
        else if (done)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            k_reg <= k_reg + 3'd1;
        end
    end

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (k_reg <= K_LAST))
        else $error("vertex counter ran past the last vertex");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && quad_reg.status != ST_VERTEX) |-> (k_reg == 3'd0))
        else $error("status result advanced the vertex counter");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> !b_valid_reg)
        else $error("result stage stayed full after its last transaction");

endmodule

`default_nettype wire

### rtl/sprite_quad_vertex_batcher.sv
// Sprite quad batcher. Each input transaction on s_* is one command: s_tuser
// selects add quad, clear one layer or clear all layers. An accepted add
// produces six vertex transactions on m_* (a triangle strip with the first
// and last corners doubled, m_tlast on the sixth); a rejected add or a clear
// produces one status transaction with m_tlast set. Command code 3 produces
// nothing.
// A command passes from the input register into the result stage, which drives
// m_*; vertices leave at one per cycle while m_tready is high. The input
// register takes the next command while the result stage is still emitting,
// so the output never idles while work waits.
// The per-layer quad counts live in a small memory read as a command enters
// the input register; reset marks every layer empty by clearing a valid bit each.
// Configuration writes on cfg_* are always accepted and must only be issued
// while no command is in flight. Reset empties both stages and restores the
// register defaults. When m_tready is low the current result is held and at
// most one further command is buffered, after which s_tready drops.
`default_nettype none

module sprite_quad_vertex_batcher
    import sqvb_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    parameter int MAX_TILES  = DEF_MAX_TILES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // layer[3:0], sheet_x[15:4], sheet_y[27:16], screen_x[43:28],
    // screen_y[59:44], quad_width[71:60], quad_height[83:72], flip[85:84],
    // rgba[117:86], zero fill above
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  wire logic [IN_USER_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // slot_index[13:0], vert_x[29:14], vert_y[45:30], tex_u[62:46],
    // tex_v[79:63], vert_rgba[111:80]
    output logic [OUT_DATA_W-1:0]       m_tdata,
    // status[2:0]
    output logic [OUT_USER_W-1:0]       m_tuser,
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CW = $clog2(MAX_TILES + 1);

    logic [2:0]   default_layer_reg;
    logic [3:0]   layers_in_use_reg;
    logic [8:0]   tiles_per_layer_reg;
    logic [31:0]  recip_w_reg;
    logic [31:0]  recip_h_reg;
    logic         texture_loaded_reg;

    sqvb_item_t   item_in;
    sqvb_item_t   item_reg;
    sqvb_mode_t   mode_reg;
    logic         a_valid_reg;
    logic         accept;
    logic         a_take;
    logic         load;
    logic         emit_free;
    logic [LW-1:0] rd_addr;
    logic [CW-1:0] count;
    sqvb_quad_t   quad;
    sqvb_cnt_wr_t wr_raw;
    sqvb_cnt_wr_t wr;
    logic [LW-1:0] wr_addr;
    logic [CW-1:0] wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_layer_reg   <= 3'd0;
            layers_in_use_reg   <= 4'd8;
            tiles_per_layer_reg <= 9'd256;
            recip_w_reg         <= 32'd1048576;
            recip_h_reg         <= 32'd1048576;
            texture_loaded_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (sqvb_reg_t'(cfg_index))
                REG_DEFAULT_LAYER:   default_layer_reg   <= cfg_data[2:0];
                REG_LAYERS_IN_USE:   layers_in_use_reg   <= cfg_data[3:0];
                REG_TILES_PER_LAYER: tiles_per_layer_reg <= cfg_data[8:0];
                REG_RECIP_WIDTH:     recip_w_reg         <= cfg_data;
                REG_RECIP_HEIGHT:    recip_h_reg         <= cfg_data;
                REG_TEXTURE_LOADED:  texture_loaded_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        item_in  = sqvb_item_t'(s_tdata);
        a_take   = a_valid_reg && emit_free;
        s_tready = !a_valid_reg || emit_free;
        accept   = s_tvalid && s_tready;
        load     = a_take && (mode_reg != MODE_NONE);
        rd_addr  = LW'(eff_layer(item_in.layer, default_layer_reg));
        wr.wr_en   = a_take && wr_raw.wr_en;
        wr.clr_all = a_take && wr_raw.clr_all;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
            mode_reg <= sqvb_mode_t'(s_tuser);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_take)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    sqvb_counts #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_TILES  (MAX_TILES)
    ) u_counts (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .count   (count)
    );

    sqvb_quad #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_TILES  (MAX_TILES)
    ) u_quad (
        .item            (item_reg),
        .mode            (mode_reg),
        .default_layer   (default_layer_reg),
        .layers_in_use   (layers_in_use_reg),
        .tiles_per_layer (tiles_per_layer_reg),
        .recip_w         (recip_w_reg),
        .recip_h         (recip_h_reg),
        .texture_loaded  (texture_loaded_reg),
        .count           (count),
        .quad            (quad),
        .wr              (wr_raw),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data)
    );

    sqvb_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .quad_in  (quad),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### verif/sqvb_vertex_checker.sv
module sqvb_vertex_checker
    import sqvb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // layer, sheet_x, sheet_y, screen_x, screen_y, quad_width, quad_height, flip, rgba
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // mode
    input  wire logic [IN_USER_W-1:0]   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // slot_index, vert_x, vert_y, tex_u, tex_v, vert_rgba
    input  wire logic [OUT_DATA_W-1:0]  m_tdata,
    // status
    input  wire logic [OUT_USER_W-1:0]  m_tuser,
    input  wire logic                   m_tlast,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sqvb_status_t status;
        logic [13:0]  slot;
        logic [15:0]  vert_x;
        logic [15:0]  vert_y;
        logic [16:0]  tex_u;
        logic [16:0]  tex_v;
        logic [31:0]  rgba;
        logic         last;
    } vertex_t;

    // Layout of m_tdata, highest bits first.
    typedef struct packed {
        logic [31:0] rgba;
        logic [16:0] tex_v;
        logic [16:0] tex_u;
        logic [15:0] vert_y;
        logic [15:0] vert_x;
        logic [13:0] slot;
    } vertex_bus_t;

    logic [2:0]  def_layer;
    logic [3:0]  layers_used;
    logic [8:0]  tiles_reg;
    logic [31:0] recip_w;
    logic [31:0] recip_h;
    logic        tex_loaded;
    logic [8:0]  quad_count [8];
    vertex_t     expected_vertices [$];
    int          errors;

    function automatic logic [16:0] q16_coord(input int texel, input logic [31:0] recip);
        logic [63:0] prod;
        prod = (64'(texel) * 64'(recip)) >> 16;
        return (prod > 64'd131071) ? 17'h1ffff : prod[16:0];
    endfunction

    function automatic logic [15:0] clamp16(input int pos);
        if (pos > 32767)
        begin
            return 16'h7fff;
        end
        if (pos < -32768)
        begin
            return 16'h8000;
        end
        return pos[15:0];
    endfunction

    task automatic push_status(input sqvb_status_t code);
        vertex_t vtx;
        vtx = '0;
        vtx.status = code;
        vtx.last = 1'b1;
        expected_vertices.push_back(vtx);
    endtask

    task automatic predict_command(input sqvb_mode_t mode, input sqvb_item_t it);
        int eff;
        int cap;
        int count;
        int base;
        int px;
        int py;
        logic [16:0] u_near;
        logic [16:0] u_far;
        logic [16:0] v_near;
        logic [16:0] v_far;
        logic [16:0] tmp;
        logic [15:0] xl;
        logic [15:0] xr;
        logic [15:0] yt;
        logic [15:0] yb;
        bit right;
        bit bottom;
        vertex_t vtx;
        if (mode == MODE_NONE)
        begin
            return;
        end
        // Clearing one layer with the default-layer code clears every layer.
        if (mode == MODE_CLEAR_ALL || (mode == MODE_CLEAR_ONE && it.layer == -4'sd1))
        begin
            foreach (quad_count[i])
            begin
                quad_count[i] = '0;
            end
            push_status(ST_CLEARED);
            return;
        end
        if (it.layer == -4'sd1)
        begin
            eff = def_layer;
        end
        else
        begin
            eff = $signed(it.layer);
        end
        if (mode == MODE_ADD && !tex_loaded)
        begin
            push_status(ST_NO_TEXTURE);
            return;
        end
        if (eff < 0 || eff >= int'(layers_used) || eff >= DEF_MAX_LAYERS)
        begin
            push_status(ST_BAD_LAYER);
            return;
        end
        if (mode == MODE_CLEAR_ONE)
        begin
            quad_count[eff] = '0;
            push_status(ST_CLEARED);
            return;
        end
        cap = (tiles_reg > DEF_MAX_TILES) ? DEF_MAX_TILES : tiles_reg;
        count = quad_count[eff];
        if (count >= cap)
        begin
            push_status(ST_LAYER_FULL);
            return;
        end
        u_near = q16_coord(int'(it.sheet_x), recip_w);
        u_far  = q16_coord(int'(it.sheet_x) + int'(it.quad_width), recip_w);
        v_near = q16_coord(int'(it.sheet_y), recip_h);
        v_far  = q16_coord(int'(it.sheet_y) + int'(it.quad_height), recip_h);
        if (it.flip[0])
        begin
            tmp = u_near;
            u_near = u_far;
            u_far = tmp;
        end
        if (it.flip[1])
        begin
            tmp = v_near;
            v_near = v_far;
            v_far = tmp;
        end
        px = $signed(it.screen_x);
        py = $signed(it.screen_y);
        xl = clamp16(px);
        xr = clamp16(px + int'(it.quad_width));
        yt = clamp16(py);
        yb = clamp16(py + int'(it.quad_height));
        base = (eff * cap + count) * 6;
        // Strip order: top-left twice, top-right, bottom-left, bottom-right twice.
        for (int k = 0; k < 6; k++)
        begin
            right = (k == 2 || k >= 4);
            bottom = (k >= 3);
            vtx.status = ST_VERTEX;
            vtx.slot   = 14'(base + k);
            vtx.vert_x = right ? xr : xl;
            vtx.vert_y = bottom ? yb : yt;
            vtx.tex_u  = right ? u_far : u_near;
            vtx.tex_v  = bottom ? v_far : v_near;
            vtx.rgba   = it.rgba;
            vtx.last   = (k == 5);
            expected_vertices.push_back(vtx);
        end
        quad_count[eff] = 9'(count + 1);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        vertex_t     want;
        vertex_bus_t got;
        if (!rst_n)
        begin
            def_layer   = 3'd0;
            layers_used = 4'd8;
            tiles_reg   = 9'd256;
            recip_w     = 32'h0010_0000;
            recip_h     = 32'h0010_0000;
            tex_loaded  = 1'b0;
            foreach (quad_count[i])
            begin
                quad_count[i] = '0;
            end
            expected_vertices.delete();
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (sqvb_reg_t'(cfg_index))
                    REG_DEFAULT_LAYER:   def_layer   = cfg_data[2:0];
                    REG_LAYERS_IN_USE:   layers_used = cfg_data[3:0];
                    REG_TILES_PER_LAYER: tiles_reg   = cfg_data[8:0];
                    REG_RECIP_WIDTH:     recip_w     = cfg_data;
                    REG_RECIP_HEIGHT:    recip_h     = cfg_data;
                    REG_TEXTURE_LOADED:  tex_loaded  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_command(sqvb_mode_t'(s_tuser), sqvb_item_t'(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_vertices.size() == 0)
                begin
                    $error("result with nothing expected: status %0d slot %0d",
                           m_tuser, got.slot);
                    errors++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("slot_index", want.slot, got.slot);
                    check_field("vert_x", want.vert_x, got.vert_x);
                    check_field("vert_y", want.vert_y, got.vert_y);
                    check_field("tex_u", want.tex_u, got.tex_u);
                    check_field("tex_v", want.tex_v, got.tex_v);
                    check_field("vert_rgba", want.rgba, got.rgba);
                    check_field("last", want.last, m_tlast);
                end
            end
            fail_count <= errors;
            outstanding <= expected_vertices.size();
        end
    end

endmodule

### verif/tb_sprite_quad_vertex_batcher.sv
module tb_sprite_quad_vertex_batcher;
    timeunit 1ns;
    timeprecision 1ps;

    import sqvb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // layer, sheet_x, sheet_y, screen_x, screen_y, quad_width, quad_height, flip, rgba
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    // mode
    logic [IN_USER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // slot_index, vert_x, vert_y, tex_u, tex_v, vert_rgba
    logic [OUT_DATA_W-1:0]  m_tdata;
    // status
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int outstanding;
    int gap_pct = 25;
    int stall_pct = 25;
    int stall_left = 0;
    int cycle_count = 0;

    sprite_quad_vertex_batcher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sqvb_vertex_checker vertex_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Vertex sink: ready drops in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(17);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic sqvb_item_t make_item(input int layer, input int sx, input int sy,
                                             input int px, input int py, input int w,
                                             input int h, input int flip,
                                             input logic [31:0] rgba);
        sqvb_item_t it;
        it = '0;
        it.layer       = 4'(layer);
        it.sheet_x     = 12'(sx);
        it.sheet_y     = 12'(sy);
        it.screen_x    = 16'(px);
        it.screen_y    = 16'(py);
        it.quad_width  = 12'(w);
        it.quad_height = 12'(h);
        it.flip        = 2'(flip);
        it.rgba        = rgba;
        return it;
    endfunction

    function automatic sqvb_item_t random_item();
        sqvb_item_t it;
        it = '0;
        case ($urandom_range(9))
            0:       it.layer = 4'($urandom_range(14, 8));
            1, 2:    it.layer = -4'sd1;
            default: it.layer = 4'($urandom_range(7));
        endcase
        it.sheet_x     = 12'($urandom);
        it.sheet_y     = 12'($urandom);
        it.screen_x    = 16'($urandom);
        it.screen_y    = 16'($urandom);
        it.quad_width  = 12'($urandom);
        it.quad_height = 12'($urandom);
        it.flip        = 2'($urandom);
        it.rgba        = $urandom;
        // Small sprites near the origin keep screen positions unsaturated.
        if ($urandom_range(2) == 0)
        begin
            it.sheet_x     = 12'($urandom_range(255));
            it.sheet_y     = 12'($urandom_range(255));
            it.screen_x    = 16'($urandom_range(1023));
            it.screen_y    = 16'($urandom_range(1023));
            it.quad_width  = 12'($urandom_range(64));
            it.quad_height = 12'($urandom_range(64));
        end
        if ($urandom_range(7) == 0)
        begin
            it.screen_x = $urandom_range(1) ? 16'h7fff : 16'h8000;
            it.quad_width = 12'hfff;
        end
        return it;
    endfunction

    function automatic sqvb_mode_t random_mode();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return MODE_ADD;
        end
        if (r < 84)
        begin
            return MODE_CLEAR_ONE;
        end
        if (r < 92)
        begin
            return MODE_CLEAR_ALL;
        end
        return MODE_NONE;
    endfunction

    function automatic logic [31:0] random_recip();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return 32'h0010_0000 >> $urandom_range(8);
            3:       return $urandom_range(65536, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic reg_write(input sqvb_reg_t idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [2:0] dflt, input logic [3:0] nlayers,
                             input logic [8:0] ntiles, input logic [31:0] rw,
                             input logic [31:0] rh, input logic tex);
        cfg_valid <= 1'b1;
        reg_write(REG_DEFAULT_LAYER, 32'(dflt));
        reg_write(REG_LAYERS_IN_USE, 32'(nlayers));
        reg_write(REG_TILES_PER_LAYER, 32'(ntiles));
        reg_write(REG_RECIP_WIDTH, rw);
        reg_write(REG_RECIP_HEIGHT, rh);
        reg_write(REG_TEXTURE_LOADED, 32'(tex));
        cfg_valid <= 1'b0;
    endtask

    // Returns at the edge where the command transaction completed.
    task automatic send(input sqvb_mode_t mode, input sqvb_item_t it);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= it;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Holds off new commands until every expected vertex has been seen,
    // then stays idle so that a command that produces nothing also drains.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        sqvb_mode_t mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Texture not loaded yet after reset.
        send(MODE_ADD, make_item(0, 10, 20, 100, 200, 16, 16, 0, 32'h1122_3344));
        send(MODE_NONE, random_item());
        send(MODE_CLEAR_ONE, make_item(2, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        settle();

        configure(3'd7, 4'd8, 9'd256, 32'h0010_0000, 32'h0010_0000, 1'b1);
        send(MODE_ADD, make_item(-1, 4095, 4095, 32767, -32768, 4095, 4095, 0,
                                 32'hffff_ffff));
        send(MODE_ADD, make_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send(MODE_ADD, make_item(3, 100, 7, -32768, 32767, 50, 10, 1, 32'haaaa_aaaa));
        send(MODE_ADD, make_item(3, 300, 9, -100, -200, 50, 60, 2, 32'h5555_5555));
        send(MODE_ADD, make_item(7, 1, 2, 3, 4, 5, 6, 3, 32'h0102_0304));
        send(MODE_ADD, make_item(-8, 1, 2, 3, 4, 5, 6, 0, 32'h0));
        send(MODE_CLEAR_ONE, make_item(3, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send(MODE_CLEAR_ONE, make_item(-5, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send(MODE_CLEAR_ONE, make_item(-1, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send(MODE_CLEAR_ALL, make_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        settle();

        // One layer with room for one quad; the default layer does not exist.
        configure(3'd5, 4'd1, 9'd1, 32'hffff_ffff, 32'h0, 1'b1);
        send(MODE_ADD, make_item(0, 1, 4095, -5, 5, 2, 3, 1, 32'hdead_beef));
        send(MODE_ADD, make_item(0, 1, 1, 1, 1, 1, 1, 0, 32'h1));
        send(MODE_ADD, make_item(1, 1, 1, 1, 1, 1, 1, 0, 32'h2));
        send(MODE_ADD, make_item(-1, 1, 1, 1, 1, 1, 1, 0, 32'h3));
        send(MODE_CLEAR_ONE, make_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send(MODE_ADD, make_item(0, 0, 0, 7, 8, 9, 10, 2, 32'h4));
        send(MODE_CLEAR_ONE, make_item(1, 0, 0, 0, 0, 0, 0, 0, 32'h0));

        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0: configure(3'($urandom), 4'd8, 9'd256, random_recip(), random_recip(),
                             1'b1);
                1: configure(3'd0, 4'd1, 9'd1, random_recip(), random_recip(), 1'b1);
                3: configure(3'($urandom), 4'($urandom_range(8, 1)),
                             9'($urandom_range(6, 1)), random_recip(), random_recip(),
                             $urandom_range(2) != 0);
                default: configure(3'($urandom), 4'($urandom_range(8, 1)),
                                   9'($urandom_range(6, 1)), random_recip(),
                                   random_recip(), 1'b1);
            endcase
            if (phase == 5)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = $urandom_range(40, 5);
                stall_pct = $urandom_range(40, 5);
            end
            sent = 0;
            while (sent < 20)
            begin
                mode = random_mode();
                send(mode, random_item());
                if (mode != MODE_NONE)
                begin
                    sent++;
                end
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
